// ----- design/lcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared constants, register indexes and divider handshake types for the
// range-scaled linear congruential generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgr_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int DWORD_WIDTH = 2 * WORD_WIDTH;
  localparam int CNT_WIDTH = $clog2(DWORD_WIDTH + 1);
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MULTIPLIER = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INCREMENT = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEED = CFG_INDEX_WIDTH'(3);

  localparam logic [WORD_WIDTH-1:0] MULTIPLIER_RESET = WORD_WIDTH'(1093);
  localparam logic [WORD_WIDTH-1:0] INCREMENT_RESET = WORD_WIDTH'(221587);
  localparam logic [WORD_WIDTH-1:0] MODULUS_RESET = WORD_WIDTH'(1048576);

  localparam logic [CNT_WIDTH-1:0] STEPS_HALF = CNT_WIDTH'(WORD_WIDTH);
  localparam logic [CNT_WIDTH-1:0] STEPS_FULL = CNT_WIDTH'(DWORD_WIDTH);

  typedef struct packed {
    logic                   start;
    logic [DWORD_WIDTH-1:0] dividend;
    logic [WORD_WIDTH-1:0]  init_rem;
    logic [WORD_WIDTH-1:0]  divisor;
    logic [CNT_WIDTH-1:0]   steps;
  } lcgr_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [WORD_WIDTH-1:0] quotient;
    logic [WORD_WIDTH-1:0] remainder;
  } lcgr_div_rsp_t;

endpackage

`default_nettype wire

// ----- design/lcgr_if.sv -----
// ----------------------------------------------------------------------------
// lcgr interfaces
// Valid/ready channels for draw requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcgr_draw_if import lcgr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] draw_range;

  modport source (output valid, output draw_range, input ready);
  modport sink (input valid, input draw_range, output ready);
endinterface

interface lcgr_result_if import lcgr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] raw_value;
  logic [WORD_WIDTH-1:0] scaled_value;

  modport source (output valid, output raw_value, output scaled_value, input ready);
  modport sink (input valid, input raw_value, input scaled_value, output ready);
endinterface

interface lcgr_cfg_if import lcgr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [WORD_WIDTH-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/lcgr_div.sv -----
// ----------------------------------------------------------------------------
// lcgr_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller gives
// a start remainder below the divisor and the number of dividend bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgr_div import lcgr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lcgr_div_req_t req,
  output lcgr_div_rsp_t      rsp
);

  logic                   busy;
  logic                   done;
  logic [CNT_WIDTH-1:0]   cnt;
  logic [DWORD_WIDTH-1:0] dvd;
  logic [WORD_WIDTH-1:0]  rem;
  logic [WORD_WIDTH-1:0]  divisor;

  logic [WORD_WIDTH:0]    shifted;
  logic [WORD_WIDTH:0]    diff;
  logic                   fits;
  logic [WORD_WIDTH-1:0]  rem_next;

  always_comb begin
    shifted = {rem, dvd[DWORD_WIDTH-1]};
    diff = shifted - {1'b0, divisor};
    fits = shifted >= {1'b0, divisor};
    rem_next = fits ? diff[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.steps;
      end else if (busy) begin
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= req.init_rem;
      divisor <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[DWORD_WIDTH-2:0], fits};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = dvd[WORD_WIDTH-1:0];
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ----- design/lcg_range_random.sv -----
// ----------------------------------------------------------------------------
// lcg_range_random
// Linear congruential generator with range scaling on a shared serial divider.
// ----------------------------------------------------------------------------
// Order: scale multiply, scale check, scale divide, step multiply, add,
// reduce, step divide, done; a zero modulus or saturating scale skips divides.
// Throughput: one draw at a time, set by the one-bit-per-cycle divider that
// does the scaling quotient (WORD_WIDTH steps) and the state reduction
// (2*WORD_WIDTH steps). A seed write holds the ports while it is reduced.
// Reset: synchronous; registers take their reset values, state is zero.
`default_nettype none

module lcg_range_random import lcgr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  lcgr_cfg_if.sink      cfg,
  lcgr_draw_if.sink     draw,
  lcgr_result_if.source result
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SEED      = 10'b00_0000_0010,
    S_MUL_SCALE = 10'b00_0000_0100,
    S_SCALE_CHK = 10'b00_0000_1000,
    S_DIV_SCALE = 10'b00_0001_0000,
    S_MUL_STEP  = 10'b00_0010_0000,
    S_ADD       = 10'b00_0100_0000,
    S_REDUCE    = 10'b00_1000_0000,
    S_DIV_STEP  = 10'b01_0000_0000,
    S_DONE      = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [WORD_WIDTH-1:0]  multiplier;
  logic [WORD_WIDTH-1:0]  increment;
  logic [WORD_WIDTH-1:0]  modulus;
  logic [WORD_WIDTH-1:0]  gen_state;
  logic [WORD_WIDTH-1:0]  next_x;
  logic [WORD_WIDTH-1:0]  range_q;
  logic [WORD_WIDTH-1:0]  scaled;
  logic [DWORD_WIDTH-1:0] prod;

  logic                   res_valid;
  logic [WORD_WIDTH-1:0]  res_raw;
  logic [WORD_WIDTH-1:0]  res_scaled;

  logic                   cfg_fire;
  logic                   draw_fire;
  logic                   mod_zero;
  logic [WORD_WIDTH-1:0]  prod_hi;
  logic [WORD_WIDTH-1:0]  mul_a;
  logic [DWORD_WIDTH-1:0] mul_p;
  logic                   out_free;

  lcgr_div_req_t div_req;
  lcgr_div_rsp_t div_rsp;

  // a register write takes the idle window ahead of a draw
  assign cfg.ready = (state == S_IDLE);
  assign draw.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign draw_fire = draw.valid && draw.ready;
  assign mod_zero = (modulus == '0);
  assign prod_hi = prod[DWORD_WIDTH-1:WORD_WIDTH];
  assign out_free = !res_valid || result.ready;

  // one multiplier, shared by the scaling and the state update
  assign mul_a = (state == S_MUL_SCALE) ? range_q : multiplier;
  assign mul_p = DWORD_WIDTH'(mul_a) * DWORD_WIDTH'(gen_state);

  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = {prod[WORD_WIDTH-1:0], {WORD_WIDTH{1'b0}}};
    div_req.init_rem = prod_hi;
    div_req.divisor = modulus;
    div_req.steps = STEPS_HALF;
    case (state)
      S_IDLE: begin
        if (cfg_fire && cfg.index == REG_SEED && !mod_zero) begin
          div_req.start = 1'b1;
          div_req.dividend = {cfg.data, {WORD_WIDTH{1'b0}}};
          div_req.init_rem = '0;
        end
      end
      S_SCALE_CHK: begin
        // high word already below the modulus, so the quotient fits a word
        div_req.start = !mod_zero && (prod_hi < modulus);
      end
      S_REDUCE: begin
        div_req.start = !mod_zero;
        div_req.dividend = prod;
        div_req.init_rem = '0;
        div_req.steps = STEPS_FULL;
      end
      default: begin
      end
    endcase
  end

  lcgr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      multiplier <= MULTIPLIER_RESET;
      increment <= INCREMENT_RESET;
      modulus <= MODULUS_RESET;
      gen_state <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            case (cfg.index)
              REG_MULTIPLIER: multiplier <= cfg.data;
              REG_INCREMENT:  increment <= cfg.data;
              REG_MODULUS:    modulus <= cfg.data;
              REG_SEED: begin
                if (mod_zero) begin
                  gen_state <= cfg.data;
                end else begin
                  state <= S_SEED;
                end
              end
              default: begin
              end
            endcase
          end else if (draw_fire) begin
            state <= S_MUL_SCALE;
          end
        end
        S_SEED: begin
          if (div_rsp.done) begin
            gen_state <= div_rsp.remainder;
            state <= S_IDLE;
          end
        end
        S_MUL_SCALE: state <= S_SCALE_CHK;
        S_SCALE_CHK: begin
          if (mod_zero || prod_hi >= modulus) begin
            state <= S_MUL_STEP;
          end else begin
            state <= S_DIV_SCALE;
          end
        end
        S_DIV_SCALE: begin
          if (div_rsp.done) begin
            state <= S_MUL_STEP;
          end
        end
        S_MUL_STEP: state <= S_ADD;
        S_ADD:      state <= S_REDUCE;
        S_REDUCE: begin
          state <= mod_zero ? S_DONE : S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            gen_state <= next_x;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (draw_fire) begin
      range_q <= draw.draw_range;
    end
    case (state)
      S_MUL_SCALE: prod <= mul_p;
      S_MUL_STEP:  prod <= mul_p;
      S_ADD:       prod <= prod + {{WORD_WIDTH{1'b0}}, increment};
      default: begin
      end
    endcase
    if (state == S_SCALE_CHK) begin
      if (mod_zero) begin
        scaled <= prod_hi;
      end else if (prod_hi >= modulus) begin
        // quotient does not fit a word
        scaled <= '1;
      end
    end
    if (state == S_DIV_SCALE && div_rsp.done) begin
      scaled <= div_rsp.quotient;
    end
    if (state == S_REDUCE && mod_zero) begin
      next_x <= prod[WORD_WIDTH-1:0];
    end
    if (state == S_DIV_STEP && div_rsp.done) begin
      next_x <= div_rsp.remainder;
    end
    if (state == S_DONE && out_free) begin
      res_raw <= gen_state;
      res_scaled <= scaled;
    end
  end

  assign result.valid = res_valid;
  assign result.raw_value = res_raw;
  assign result.scaled_value = res_scaled;

endmodule

`default_nettype wire

// ----- design/lcgr_checker.sv -----
// ----------------------------------------------------------------------------
// lcgr_checker
// Port-level checks on the generator's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgr_checker import lcgr_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic                  draw_valid,
  input wire logic                  draw_ready,
  input wire logic                  res_valid,
  input wire logic                  res_ready,
  input wire logic [WORD_WIDTH-1:0] raw_value,
  input wire logic [WORD_WIDTH-1:0] scaled_value
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(raw_value) && $stable(scaled_value))
    else $error("result changed while stalled");

  // one draw at a time: no new item right after an accepted one
  assert property (@(posedge clk) disable iff (rst)
    draw_valid && draw_ready |=> !draw_ready)
    else $error("draw accepted while busy");

  // draws are taken in the idle window only when no write is offered
  assert property (@(posedge clk) disable iff (rst)
    draw_ready == (cfg_ready && !cfg_valid))
    else $error("cfg and draw ready disagree");

  // the result of an accepted item cannot appear on the next edge
  assert property (@(posedge clk) disable iff (rst)
    draw_valid && draw_ready && !cfg_valid |=> !$rose(res_valid))
    else $error("result too early");

  assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind lcg_range_random lcgr_checker u_lcgr_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready),
  .draw_valid   (draw.valid),
  .draw_ready   (draw.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .raw_value    (result.raw_value),
  .scaled_value (result.scaled_value)
);

`default_nettype wire

// ----- tb/sv/lcg_range_random_tb.sv -----
// ----------------------------------------------------------------------------
// lcg_range_random_tb
// Self-checking bench for the range-scaled linear congruential generator.
// Register writes and draw requests go in over valid/ready channels. A local
// model of the generator state predicts raw and scaled values for every
// accepted draw, and each returned item is checked in order. Directed tests
// cover reset values, register extremes, zero modulus and a state left above
// a rewritten modulus. Random tests then reprogram the generator between
// batches under three idling patterns.
// ----------------------------------------------------------------------------
module lcg_range_random_tb import lcgr_pkg::*; ();

  typedef logic [WORD_WIDTH-1:0]  word_t;
  typedef logic [DWORD_WIDTH-1:0] dword_t;

  typedef struct packed {
    word_t raw_value;
    word_t scaled_value;
  } draw_result_t;

  localparam int  CYCLE_LIMIT = 1_500_000;
  localparam int  DRAIN_CYCLES = 3 * WORD_WIDTH + 100;
  localparam word_t WORD_MAX = '1;

  logic clk = 1'b0;
  logic rst;

  lcgr_cfg_if    cfg_ch ();
  lcgr_draw_if   draw_ch ();
  lcgr_result_if result_ch ();

  lcg_range_random dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .draw   (draw_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  // local copy of the generator registers and state
  word_t mult_reg;
  word_t incr_reg;
  word_t modulus_reg;
  word_t lcg_state;

  draw_result_t draws_in_flight[$];
  draw_result_t oldest_draw;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int draws_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int zero_mod_draws = 0;
  int zero_range_draws = 0;
  int saturated_draws = 0;
  int stale_draws = 0;
  int cycle_count = 0;

  // raw value is the current state, scaled value floor(range*state/modulus)
  // saturated to a word, then the state steps to (a*x+c) mod m; modulus zero means 2^WORD_WIDTH
  function automatic draw_result_t next_draw(input word_t range_val);
    dword_t       prod;
    dword_t       quot;
    dword_t       step;
    draw_result_t res;
    prod = dword_t'(range_val) * dword_t'(lcg_state);
    if (modulus_reg == '0) begin
      quot = prod >> WORD_WIDTH;
      zero_mod_draws++;
    end else begin
      quot = prod / dword_t'(modulus_reg);
      if (lcg_state >= modulus_reg) stale_draws++;
    end
    if (range_val == '0) zero_range_draws++;
    res.raw_value = lcg_state;
    if (quot > dword_t'(WORD_MAX)) begin
      res.scaled_value = WORD_MAX;
      saturated_draws++;
    end else begin
      res.scaled_value = quot[WORD_WIDTH-1:0];
    end
    step = dword_t'(mult_reg) * dword_t'(lcg_state) + dword_t'(incr_reg);
    if (modulus_reg == '0) lcg_state = step[WORD_WIDTH-1:0];
    else lcg_state = word_t'(step % dword_t'(modulus_reg));
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input word_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MULTIPLIER: mult_reg = value;
      REG_INCREMENT:  incr_reg = value;
      REG_MODULUS:    modulus_reg = value;
      REG_SEED: begin
        lcg_state = (modulus_reg == '0) ? value : value % modulus_reg;
      end
      default: ;
    endcase
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_draw(input word_t range_val);
    while ($urandom_range(99) < send_idle_pct) begin
      draw_ch.valid <= 1'b0;
      @(posedge clk);
    end
    draw_ch.valid      <= 1'b1;
    draw_ch.draw_range <= range_val;
    @(posedge clk);
    while (!draw_ch.ready) @(posedge clk);
    draws_in_flight.push_back(next_draw(range_val));
    draws_sent++;
  endtask

  // hold off new draws until every outstanding item has come back
  task automatic drain_draws();
    draw_ch.valid <= 1'b0;
    do @(posedge clk); while (draws_in_flight.size() != 0);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(6))
      0:       return '0;
      1:       return WORD_MAX;
      2:       return word_t'($urandom_range(255));
      3:       return word_t'(1) << $urandom_range(WORD_WIDTH - 1);
      4:       return WORD_MAX - word_t'($urandom_range(255));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t pick_modulus();
    case ($urandom_range(7))
      0:       return '0;
      1:       return word_t'(1);
      2:       return WORD_MAX;
      3:       return word_t'($urandom_range(1000, 2));
      4:       return word_t'(1) << $urandom_range(WORD_WIDTH - 1);
      5:       return MODULUS_RESET;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic test_reset_values();
    send_draw('0);
    send_draw(WORD_MAX);
    send_draw(word_t'(1));
    send_draw(word_t'(1000));
    send_draw(word_t'($urandom));
    drain_draws();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_MODULUS, WORD_MAX);
    write_reg(REG_MULTIPLIER, WORD_MAX);
    write_reg(REG_INCREMENT, WORD_MAX);
    write_reg(REG_SEED, WORD_MAX - 1);
    send_draw(WORD_MAX);
    send_draw(WORD_MAX);
    drain_draws();
    write_reg(REG_MULTIPLIER, '0);
    write_reg(REG_INCREMENT, '0);
    write_reg(REG_MODULUS, word_t'(1));
    write_reg(REG_SEED, WORD_MAX);
    send_draw(WORD_MAX);
    send_draw('0);
    drain_draws();
  endtask

  task automatic test_zero_modulus();
    write_reg(REG_MULTIPLIER, word_t'(1664525));
    write_reg(REG_INCREMENT, word_t'(1013904223));
    write_reg(REG_MODULUS, '0);
    write_reg(REG_SEED, WORD_MAX);
    send_draw(WORD_MAX);
    send_draw(word_t'(1));
    send_draw('0);
    send_draw(word_t'(1) << (WORD_WIDTH - 1));
    drain_draws();
  endtask

  // state seeded under a wide modulus, then modulus shrunk under it
  task automatic test_stale_state();
    write_reg(REG_SEED, WORD_MAX - 1);
    write_reg(REG_MODULUS, word_t'(1));
    send_draw(WORD_MAX);
    drain_draws();
    write_reg(REG_MODULUS, '0);
    write_reg(REG_SEED, word_t'(32'hDEAD_BEEF));
    write_reg(REG_MODULUS, word_t'(3));
    send_draw(word_t'(1));
    send_draw(word_t'(7));
    drain_draws();
    write_reg(REG_SEED, word_t'(32'hDEAD_BEEF));
    send_draw(word_t'(7));
    drain_draws();
  endtask

  task automatic test_random_draws(input int n_items, input int send_pct, input int recv_pct);
    int left;
    int batch;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    left = n_items;
    while (left > 0) begin
      drain_draws();
      if ($urandom_range(2) != 0) write_reg(REG_MULTIPLIER, pick_word());
      if ($urandom_range(2) != 0) write_reg(REG_INCREMENT, pick_word());
      if ($urandom_range(2) != 0) write_reg(REG_MODULUS, pick_modulus());
      // skipping the seed now and then leaves the state above a new modulus
      if ($urandom_range(5) != 0) write_reg(REG_SEED, pick_word());
      batch = $urandom_range(120, 20);
      if (batch > left) batch = left;
      repeat (batch) send_draw(pick_word());
      left -= batch;
    end
    drain_draws();
  endtask

  task automatic finish_run();
    drain_draws();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (draws_in_flight.size() != 0) begin
      $error("%0d draws never answered", draws_in_flight.size());
      mismatches++;
    end
    $display("covered %0d draws and %0d register writes under three idling patterns",
             draws_sent, reg_writes);
    $display("special draws: %0d zero modulus, %0d zero range, %0d saturated, %0d stale state",
             zero_mod_draws, zero_range_draws, saturated_draws, stale_draws);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (draws_in_flight.size() == 0) begin
          $error("result item with no draw outstanding: raw_value %0d scaled_value %0d",
                 result_ch.raw_value, result_ch.scaled_value);
          mismatches++;
        end else begin
          oldest_draw = draws_in_flight.pop_front();
          if (result_ch.raw_value !== oldest_draw.raw_value) begin
            $error("raw_value: expected %0d, actual %0d",
                   oldest_draw.raw_value, result_ch.raw_value);
            mismatches++;
          end
          if (result_ch.scaled_value !== oldest_draw.scaled_value) begin
            $error("scaled_value: expected %0d, actual %0d",
                   oldest_draw.scaled_value, result_ch.scaled_value);
            mismatches++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_MULTIPLIER;
    cfg_ch.data        = '0;
    draw_ch.valid      = 1'b0;
    draw_ch.draw_range = '0;
    mult_reg           = MULTIPLIER_RESET;
    incr_reg           = INCREMENT_RESET;
    modulus_reg        = MODULUS_RESET;
    lcg_state          = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 61;
    test_reset_values();
    test_register_extremes();
    test_zero_modulus();
    test_stale_state();
    test_random_draws(600, 24, 61);
    test_random_draws(600, 61, 24);
    test_random_draws(500, 0, 0);
    finish_run();
  end

endmodule
